>>> rtl/frgr_pkg.sv
// shared types and constants of the fragment reassembler
package frgr_pkg;

   localparam int CHUNK_BYTES  = 256;
   localparam int MAX_MESSAGE  = 4096;

   localparam int SIZE_W  = 13;
   localparam int PSIZE_W = 16;
   localparam int LEN_W   = 9;
   localparam int POS_W   = 9;
   localparam int ADDR_W  = 12;
   localparam int TYPE_W  = 3;

   localparam logic [TYPE_W-1:0] CT_SINGLE = 3'd0;
   localparam logic [TYPE_W-1:0] CT_START  = 3'd1;
   localparam logic [TYPE_W-1:0] CT_CONT   = 3'd2;
   localparam logic [TYPE_W-1:0] CT_END    = 3'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_MESSAGE);
   localparam logic [LEN_W-1:0]  CHUNK_LEN  = LEN_W'(CHUNK_BYTES);
   localparam logic [POS_W-1:0]  POS_SAT    = '1;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_SINGLE  = 3'd1,
      KIND_START   = 3'd2,
      KIND_CONT    = 3'd3,
      KIND_END     = 3'd4,
      KIND_IGNORED = 3'd5
   } kind_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  chunk_type;
      logic [PSIZE_W-1:0] payload_len;
      logic [7:0]         byte_value;
      logic               first_byte;
      logic               last_byte;
   } req_item_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_address;
      logic [7:0]        write_data;
      logic              message_done;
      logic              chunk_ignored;
   } rsp_item_type;

endpackage

>>> rtl/frgr_engine.sv
// reassembly state and per-byte decision logic
module frgr_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [frgr_pkg::SIZE_W-1:0]     buffer_size,
   input  frgr_pkg::req_item_type          item,
   output frgr_pkg::rsp_item_type          result
);

   logic [frgr_pkg::SIZE_W-1:0] offset_ff, offset_in;
   logic                        armed_ff, armed_in;
   logic [frgr_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [frgr_pkg::LEN_W-1:0]  copy_ff, copy_in;
   frgr_pkg::kind_type          kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         armed_ff  <= 1'b0;
         pos_ff    <= '0;
         copy_ff   <= '0;
         kind_ff   <= frgr_pkg::KIND_NONE;
      end else if (step) begin
         offset_ff <= offset_in;
         armed_ff  <= armed_in;
         pos_ff    <= pos_in;
         copy_ff   <= copy_in;
         kind_ff   <= kind_in;
      end
   end

   always_comb begin
      logic [frgr_pkg::SIZE_W-1:0] size;
      logic [frgr_pkg::LEN_W-1:0]  actual;
      logic [frgr_pkg::SIZE_W-1:0] room;
      logic [frgr_pkg::POS_W-1:0]  pos;
      logic [frgr_pkg::LEN_W-1:0]  copy;
      frgr_pkg::kind_type          kind;

      size   = (buffer_size > frgr_pkg::SIZE_MAX) ? frgr_pkg::SIZE_MAX : buffer_size;
      actual = (item.payload_len != '0 &&
                item.payload_len <= frgr_pkg::PSIZE_W'(frgr_pkg::CHUNK_BYTES))
               ? item.payload_len[frgr_pkg::LEN_W-1:0] : frgr_pkg::CHUNK_LEN;
      room   = (offset_ff < size) ? size - offset_ff : '0;

      offset_in = offset_ff;
      armed_in  = armed_ff;
      pos       = pos_ff;
      copy      = copy_ff;
      kind      = kind_ff;
      result    = '0;

      // a first mark opens a new chunk, dropping any open one
      if (item.first_byte) begin
         pos  = '0;
         copy = '0;
         kind = frgr_pkg::KIND_IGNORED;
         if (size != '0) begin
            case (item.chunk_type)
               frgr_pkg::CT_SINGLE: begin
                  kind = frgr_pkg::KIND_SINGLE;
                  copy = (size < frgr_pkg::SIZE_W'(actual)) ? size[frgr_pkg::LEN_W-1:0]
                                                            : actual;
               end
               frgr_pkg::CT_START: begin
                  offset_in = '0;
                  armed_in  = 1'b1;
                  kind      = frgr_pkg::KIND_START;
                  copy = (size < frgr_pkg::SIZE_W'(actual)) ? size[frgr_pkg::LEN_W-1:0]
                                                            : actual;
               end
               frgr_pkg::CT_CONT, frgr_pkg::CT_END: begin
                  if (armed_ff) begin
                     kind = (item.chunk_type == frgr_pkg::CT_CONT) ? frgr_pkg::KIND_CONT
                                                                   : frgr_pkg::KIND_END;
                     copy = (room < frgr_pkg::SIZE_W'(actual)) ? room[frgr_pkg::LEN_W-1:0]
                                                               : actual;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (kind == frgr_pkg::KIND_IGNORED) begin
         result.chunk_ignored = 1'b1;
      end else if (kind != frgr_pkg::KIND_NONE) begin
         if (pos < copy) begin
            result.write_valid = 1'b1;
            result.write_data  = item.byte_value;
            if (kind == frgr_pkg::KIND_SINGLE) begin
               result.write_address = frgr_pkg::ADDR_W'(pos);
            end else begin
               result.write_address = offset_in[frgr_pkg::ADDR_W-1:0];
               offset_in            = offset_in + 1'b1;
            end
         end
         if (pos != frgr_pkg::POS_SAT) begin
            pos = pos + 1'b1;
         end
      end

      if (item.last_byte) begin
         if (kind == frgr_pkg::KIND_SINGLE || kind == frgr_pkg::KIND_END) begin
            result.message_done = 1'b1;
         end else if ((kind == frgr_pkg::KIND_START || kind == frgr_pkg::KIND_CONT) &&
                      offset_in >= size) begin
            result.message_done = 1'b1;
         end
         kind = frgr_pkg::KIND_NONE;
      end

      if (result.message_done) begin
         offset_in = '0;
         armed_in  = 1'b0;
      end

      pos_in  = pos;
      copy_in = copy;
      kind_in = kind;
   end

endmodule

>>> rtl/fragment_reassembler_core.sv
// top level of the byte-serial fragment reassembler
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata, tlast, tuser: one chunk byte
// rsp      out  rsp_tvalid/rsp_tready  tdata, tlast, tuser: store decision
// csr      in   csr_valid/csr_ready    csr_data: buffer_size
//
// one item per cycle while the result side is not stalled; an item enters the
// input register when it is accepted and its result is loaded from there into
// the result register, from which the rsp channel takes it
// reset clears the reassembly state and sets buffer_size to 4096
// a stalled result holds; the input register takes an item when it is empty
// or when its item moves on into the result register
module fragment_reassembler_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,  // payload_len, byte_value
   input  logic                        req_tlast,
   input  logic [3:0]                  req_tuser,  // chunk_type, first_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,  // write_address, write_data, zero pad
   output logic                        rsp_tlast,
   output logic [1:0]                  rsp_tuser,  // write_valid, chunk_ignored
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [frgr_pkg::SIZE_W-1:0] csr_data
);

   logic                        in_valid_ff, in_valid_in;
   frgr_pkg::req_item_type      in_item_ff, in_item_in;
   logic                        out_valid_ff, out_valid_in;
   frgr_pkg::rsp_item_type      out_item_ff;
   frgr_pkg::rsp_item_type      step_result;
   logic [frgr_pkg::SIZE_W-1:0] size_ff, size_in;
   logic                        out_free;
   logic                        advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_item_in.payload_len = req_tdata[15:0];
      in_item_in.byte_value  = req_tdata[23:16];
      in_item_in.chunk_type  = req_tuser[2:0];
      in_item_in.first_byte  = req_tuser[3];
      in_item_in.last_byte   = req_tlast;
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      size_in      = csr_valid ? csr_data : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         size_ff      <= frgr_pkg::SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   frgr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .buffer_size (size_ff),
      .item        (in_item_ff),
      .result      (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_item_ff.write_data, out_item_ff.write_address};
   assign rsp_tlast  = out_item_ff.message_done;
   assign rsp_tuser  = {out_item_ff.chunk_ignored, out_item_ff.write_valid};

endmodule

>>> tb/reassembly_checker.sv
`timescale 1ns / 100ps
// checker for the fragment reassembler: predicts each store decision and compares
module reassembly_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // payload_len, byte_value
   input  logic                        req_tlast,   // last_byte
   input  logic [3:0]                  req_tuser,   // chunk_type, first_byte
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [23:0]                 rsp_tdata,   // write_address, write_data, zero pad
   input  logic                        rsp_tlast,   // message_done
   input  logic [1:0]                  rsp_tuser,   // write_valid, chunk_ignored
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [frgr_pkg::SIZE_W-1:0] csr_data,
   output int unsigned                 mismatch_count,
   output int unsigned                 stores_pending
);

   logic [frgr_pkg::SIZE_W-1:0] buffer_size;
   logic [frgr_pkg::SIZE_W-1:0] write_offset;
   logic                        armed;
   logic [frgr_pkg::POS_W-1:0]  byte_pos;
   logic [frgr_pkg::LEN_W-1:0]  copy_len;
   frgr_pkg::kind_type          open_kind;

   frgr_pkg::rsp_item_type expected_stores[$];
   int unsigned            stores_seen;

   initial begin
      mismatch_count = 0;
      stores_pending = 0;
      stores_seen    = 0;
   end

   task automatic report_error(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got)
         report_error($sformatf("store %0d: %s expected %0d got %0d",
                                stores_seen, name, want, got));
   endtask

   function automatic logic [frgr_pkg::LEN_W-1:0] clip_len(
         logic [frgr_pkg::SIZE_W-1:0] space, logic [frgr_pkg::LEN_W-1:0] want);
      return (space < frgr_pkg::SIZE_W'(want)) ? frgr_pkg::LEN_W'(space) : want;
   endfunction

   // advances the reassembly state by one byte and returns its store decision
   function automatic frgr_pkg::rsp_item_type reassemble_byte(frgr_pkg::req_item_type b);
      frgr_pkg::rsp_item_type      r;
      logic [frgr_pkg::SIZE_W-1:0] cap;
      logic [frgr_pkg::SIZE_W-1:0] room;
      logic [frgr_pkg::LEN_W-1:0]  eff;
      r   = '0;
      cap = (buffer_size > frgr_pkg::SIZE_MAX) ? frgr_pkg::SIZE_MAX : buffer_size;
      if (b.first_byte) begin
         eff = (b.payload_len >= 1 && b.payload_len <= frgr_pkg::CHUNK_BYTES) ?
               frgr_pkg::LEN_W'(b.payload_len) : frgr_pkg::CHUNK_LEN;
         byte_pos  = '0;
         copy_len  = '0;
         open_kind = frgr_pkg::KIND_IGNORED;
         if (cap != '0) begin
            if (b.chunk_type == frgr_pkg::CT_SINGLE) begin
               open_kind = frgr_pkg::KIND_SINGLE;
               copy_len  = clip_len(cap, eff);
            end else if (b.chunk_type == frgr_pkg::CT_START) begin
               write_offset = '0;
               armed        = 1'b1;
               open_kind    = frgr_pkg::KIND_START;
               copy_len     = clip_len(cap, eff);
            end else if ((b.chunk_type == frgr_pkg::CT_CONT ||
                          b.chunk_type == frgr_pkg::CT_END) && armed) begin
               // offset can sit past a capacity that was lowered mid-message
               room      = (write_offset < cap) ? cap - write_offset : '0;
               open_kind = (b.chunk_type == frgr_pkg::CT_CONT) ? frgr_pkg::KIND_CONT
                                                               : frgr_pkg::KIND_END;
               copy_len  = clip_len(room, eff);
            end
         end
      end
      if (open_kind == frgr_pkg::KIND_IGNORED) begin
         r.chunk_ignored = 1'b1;
      end else if (open_kind != frgr_pkg::KIND_NONE) begin
         if (frgr_pkg::LEN_W'(byte_pos) < copy_len) begin
            r.write_valid = 1'b1;
            r.write_data  = b.byte_value;
            if (open_kind == frgr_pkg::KIND_SINGLE) begin
               r.write_address = frgr_pkg::ADDR_W'(byte_pos);
            end else begin
               r.write_address = write_offset[frgr_pkg::ADDR_W-1:0];
               write_offset    = write_offset + 1'b1;
            end
         end
         if (byte_pos != frgr_pkg::POS_SAT)
            byte_pos = byte_pos + 1'b1;
      end
      if (b.last_byte) begin
         if (open_kind == frgr_pkg::KIND_SINGLE || open_kind == frgr_pkg::KIND_END)
            r.message_done = 1'b1;
         else if ((open_kind == frgr_pkg::KIND_START || open_kind == frgr_pkg::KIND_CONT) &&
                  write_offset >= cap)
            r.message_done = 1'b1;
         open_kind = frgr_pkg::KIND_NONE;
      end
      if (r.message_done) begin
         write_offset = '0;
         armed        = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      frgr_pkg::req_item_type b;
      frgr_pkg::rsp_item_type want;
      if (reset) begin
         buffer_size  = frgr_pkg::SIZE_RESET;
         write_offset = '0;
         armed        = 1'b0;
         byte_pos     = '0;
         copy_len     = '0;
         open_kind    = frgr_pkg::KIND_NONE;
         expected_stores.delete();
      end else begin
         if (csr_valid && csr_ready)
            buffer_size = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stores.size() == 0) begin
               report_error($sformatf("store %0d: result with no item waiting", stores_seen));
            end else begin
               want = expected_stores.pop_front();
               check_field("write_valid", want.write_valid, rsp_tuser[0]);
               check_field("chunk_ignored", want.chunk_ignored, rsp_tuser[1]);
               check_field("write_address", want.write_address, rsp_tdata[11:0]);
               check_field("write_data", want.write_data, rsp_tdata[19:12]);
               check_field("message_done", want.message_done, rsp_tlast);
               check_field("tdata pad", 0, rsp_tdata[23:20]);
            end
            stores_seen++;
         end
         if (req_tvalid && req_tready) begin
            b.chunk_type  = req_tuser[2:0];
            b.first_byte  = req_tuser[3];
            b.payload_len = req_tdata[15:0];
            b.byte_value  = req_tdata[23:16];
            b.last_byte   = req_tlast;
            expected_stores.push_back(reassemble_byte(b));
         end
      end
      stores_pending <= expected_stores.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// testbench top of the fragment reassembler: stimulus, watchdog and verdict
module tb;

   localparam logic [frgr_pkg::TYPE_W-1:0] CT_OTHER   = 3'd4;
   localparam logic [frgr_pkg::TYPE_W-1:0] CT_UNKNOWN = 3'd7;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS = 70;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [23:0]                 req_tdata  = '0;
   logic                        req_tlast  = 1'b0;
   logic [3:0]                  req_tuser  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [23:0]                 rsp_tdata;
   logic                        rsp_tlast;
   logic [1:0]                  rsp_tuser;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [frgr_pkg::SIZE_W-1:0] csr_data   = '0;

   int unsigned mismatch_count;
   int unsigned stores_pending;
   int unsigned items_sent = 0;
   int unsigned rsp_wait   = 0;
   int unsigned quiet_cycles = 0;
   logic        no_idle    = 1'b0;

   always #5 clock = ~clock;

   fragment_reassembler_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   reassembly_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .stores_pending (stores_pending)
   );

   // result side: unless no_idle is set, stall a random number of cycles, possibly none, after each result taken
   always @(posedge clock) begin
      int unsigned n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         if (rsp_wait == 1)
            rsp_tready <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         n = no_idle ? 0 : $urandom_range(0, 14);
         if (n != 0) begin
            rsp_tready <= 1'b0;
            rsp_wait   <= n;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("fragment_reassembler_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(logic [frgr_pkg::TYPE_W-1:0] ctype, logic [15:0] psize,
                            logic [7:0] bval, logic first, logic last);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {bval, psize};
      req_tlast  <= last;
      req_tuser  <= {first, ctype};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // type and size are only read on the first byte, so later bytes carry noise there
   task automatic send_chunk(logic [frgr_pkg::TYPE_W-1:0] ctype, logic [15:0] psize,
                             int unsigned nbytes, logic close);
      for (int unsigned i = 0; i < nbytes; i++) begin
         if (i == 0)
            send_byte(ctype, psize, 8'($urandom), 1'b1, close && nbytes == 1);
         else
            send_byte(3'($urandom), 16'($urandom), 8'($urandom), 1'b0,
                      close && i == nbytes - 1);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stores_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_buffer_size(logic [frgr_pkg::SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_psize();
      int unsigned r;
      r = $urandom_range(0, 15);
      case (r)
         0: return 16'd0;
         1: return 16'($urandom_range(257, 65535));
         2: return 16'hFFFF;
         3: return 16'd256;
         4: return 16'($urandom_range(9, 40));
         default: return 16'($urandom_range(1, 8));
      endcase
   endfunction

   // byte count of a chunk: mostly its declared size when small, sometimes overlong
   function automatic int unsigned pick_length(logic [15:0] psize);
      int unsigned eff;
      int unsigned n;
      eff = (psize >= 1 && psize <= frgr_pkg::CHUNK_BYTES) ? psize : frgr_pkg::CHUNK_BYTES;
      n   = (eff <= 8) ? eff : $urandom_range(1, 8);
      if ($urandom_range(0, 49) == 0)
         n = eff;
      if ($urandom_range(0, 5) == 0)
         n += $urandom_range(1, 3);
      return n;
   endfunction

   task automatic send_message();
      logic [15:0] ps;
      int unsigned conts;
      ps = pick_psize();
      send_chunk(frgr_pkg::CT_START, ps, pick_length(ps), $urandom_range(0, 9) != 0);
      conts = $urandom_range(0, 4);
      for (int unsigned i = 0; i < conts; i++) begin
         ps = pick_psize();
         send_chunk(frgr_pkg::CT_CONT, ps, pick_length(ps), 1'b1);
      end
      if ($urandom_range(0, 7) != 0) begin
         ps = pick_psize();
         send_chunk(frgr_pkg::CT_END, ps, pick_length(ps), 1'b1);
      end
   endtask

   task automatic send_sequence();
      logic [15:0] ps;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         send_message();
      end else if (pick == 7) begin
         // bytes with no first mark, outside any chunk unless one was left open
         repeat ($urandom_range(1, 3))
            send_byte(3'($urandom), 16'($urandom), 8'($urandom), 1'b0, 1'($urandom));
      end else if (pick == 8) begin
         ps = pick_psize();
         send_chunk(frgr_pkg::CT_SINGLE, ps, pick_length(ps), 1'b1);
      end else begin
         ps = $urandom_range(0, 1) ? pick_psize() : 16'($urandom);
         send_chunk(3'($urandom), ps, $urandom_range(1, 6), $urandom_range(0, 3) != 0);
      end
   endtask

   initial begin
      logic [frgr_pkg::SIZE_W-1:0] sizes[8];
      sizes = '{frgr_pkg::SIZE_W'(4096), frgr_pkg::SIZE_W'(1), frgr_pkg::SIZE_W'(17),
                frgr_pkg::SIZE_W'(8191), frgr_pkg::SIZE_W'(0), frgr_pkg::SIZE_W'(5),
                frgr_pkg::SIZE_W'(300), frgr_pkg::SIZE_W'($urandom_range(1, 4096))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed part
      send_byte(frgr_pkg::CT_SINGLE, 16'd1, 8'h5A, 1'b0, 1'b0);
      send_byte(frgr_pkg::CT_SINGLE, 16'd2, 8'h00, 1'b1, 1'b0);
      send_byte(frgr_pkg::CT_SINGLE, 16'd2, 8'hFF, 1'b0, 1'b1);
      send_chunk(frgr_pkg::CT_START, 16'd3, 3, 1'b1);
      send_chunk(frgr_pkg::CT_CONT, 16'd1, 1, 1'b1);
      send_chunk(frgr_pkg::CT_END, 16'hFFFF, 1, 1'b1);
      send_chunk(frgr_pkg::CT_END, 16'd1, 1, 1'b1);
      send_chunk(CT_OTHER, 16'd1, 1, 1'b1);
      send_chunk(CT_UNKNOWN, 16'd0, 1, 1'b1);
      // chunk abandoned by a new first mark
      send_chunk(frgr_pkg::CT_START, 16'd4, 2, 1'b0);
      send_chunk(frgr_pkg::CT_SINGLE, 16'd0, 1, 1'b1);
      // overlong chunk: extra bytes dropped
      send_chunk(frgr_pkg::CT_SINGLE, 16'd1, 3, 1'b1);
      // capacity drops to zero in the middle of a start chunk
      send_byte(frgr_pkg::CT_START, 16'd2, 8'h11, 1'b1, 1'b0);
      wait_idle();
      write_buffer_size('0);
      send_byte(frgr_pkg::CT_SINGLE, 16'd9, 8'h22, 1'b0, 1'b1);
      send_chunk(frgr_pkg::CT_SINGLE, 16'd1, 1, 1'b1);
      wait_idle();
      write_buffer_size(frgr_pkg::SIZE_W'(4096));
      // capacity lowered below the offset mid-message
      send_chunk(frgr_pkg::CT_START, 16'd4, 4, 1'b1);
      wait_idle();
      write_buffer_size(frgr_pkg::SIZE_W'(2));
      send_chunk(frgr_pkg::CT_CONT, 16'd1, 1, 1'b1);
      wait_idle();

      // random part, one buffer size per phase
      for (int p = 0; p < 8; p++) begin
         write_buffer_size(sizes[p]);
         no_idle = (p % 3 == 2);
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) send_sequence();
         wait_idle();
      end
      no_idle = 1'b0;

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && stores_pending == 0)
         $display("fragment_reassembler_core: match");
      else
         $display("fragment_reassembler_core: mismatch");
      $finish;
   end

endmodule

>>> files.f
rtl/frgr_pkg.sv
rtl/frgr_engine.sv
rtl/fragment_reassembler_core.sv
tb/reassembly_checker.sv
tb/tb.sv
